// File: sv/pae_pkg.sv
// shared types and codes for the polynomial arithmetic engine
package pae_pkg;

    localparam logic [2:0] OP_SET   = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DERIV = 3'd3;
    localparam logic [2:0] OP_EVAL  = 3'd4;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_EVAL   = 2'd1;
    localparam logic [1:0] KIND_DERIV  = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [2:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] x_value;
        logic               stream_last;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [63:0] out_value;
        logic [2:0]         out_index;
        logic [2:0]         degree;
        logic               overflow;
        logic               run_last;
    } t_out_beat;

endpackage

// File: sv/pae_fifo.sv
// small queue of beats between the front and the back
module pae_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end
endmodule

// File: sv/pae_back.sv
// execution sequencer: holds the polynomial and walks it term by term
module pae_back #(
    parameter int MAX_TERMS = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  pae_pkg::t_in_beat i_cmd,
    output logic              o_cmd_take,
    output logic              o_res_valid,
    output pae_pkg::t_out_beat o_res,
    input  logic              i_res_full
);
    localparam int TW = $clog2(MAX_TERMS + 1);
    localparam int IW = $clog2(MAX_TERMS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DER   = 3'd2;
    localparam logic [2:0] S_EMUL  = 3'd3;
    localparam logic [2:0] S_EADD  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_EMH   = 3'd6;

    logic [2:0]         r_st;
    logic [31:0]        r_coef [MAX_TERMS];
    logic [31:0]        r_acc  [MAX_TERMS];
    logic [TW-1:0]      r_tc, r_pos, r_i;
    logic               r_povf, r_last, r_eovf;
    pae_pkg::t_in_beat  r_cmd;
    pae_pkg::t_out_beat r_res;
    logic signed [63:0] r_h;
    logic signed [95:0] r_prod;

    logic [2:0]         w_deg;
    logic [TW:0]        w_n;
    logic signed [95:0] w_sh, w_sum;
    logic               w_sat;
    logic               w_povf;
    pae_pkg::t_out_beat w_base;
    logic signed [32:0] w_ma;
    logic signed [64:0] w_mp;

    assign w_deg = (r_tc == '0) ? 3'd0 : 3'(r_tc - 1'b1);
    assign o_cmd_take  = (r_st == S_IDLE) && i_cmd_valid;
    assign o_res_valid = (r_st == S_OUT) || (r_st == S_DER);

    always_comb begin
        o_res = r_res;
        o_res.degree = w_deg;
        if (r_st == S_DER) begin
            o_res.kind      = pae_pkg::KIND_DERIV;
            o_res.out_value = 64'(signed'(r_coef[IW'(r_i)] * 32'(r_i)));
            o_res.out_index = 3'(r_i - 1'b1);
            o_res.overflow  = 1'b0;
            o_res.run_last  = ((r_i + 1'b1) == r_tc);
        end
    end

    // first result beat of a command as seen at decode
    always_comb begin
        w_base = '0;
        w_base.run_last = 1'b1;
        if (i_cmd.opcode == pae_pkg::OP_EVAL) begin
            w_base.kind = pae_pkg::KIND_EVAL;
            if (r_tc == TW'(1)) begin
                w_base.out_value = 64'(signed'(r_coef[0])) <<< FRAC_BITS;
            end
        end
        if ((i_cmd.opcode == pae_pkg::OP_SET || i_cmd.opcode == pae_pkg::OP_ADD) &&
            (32'(i_cmd.coef_index) >= 32'(MAX_TERMS))) begin
            w_base.overflow = 1'b1;
        end
    end

    // 64x32 horner product in two halves on one 33x32 multiplier
    assign w_ma = (r_st == S_EMUL) ? {1'b0, r_h[31:0]} : {r_h[63], r_h[63:32]};
    assign w_mp = 65'(w_ma) * 65'(r_cmd.x_value);

    assign w_sh  = r_prod >>> FRAC_BITS;
    assign w_sum = w_sh + (96'(signed'(r_coef[IW'(r_i - 1'b1)])) <<< FRAC_BITS);
    assign w_sat = (w_sum[95:63] != {33{w_sum[63]}});
    assign w_n   = (r_tc == '0) ? '0 : (TW+1)'(r_tc) + (TW+1)'(r_pos) - 1'b1;
    assign w_povf = r_povf || ((r_pos >= TW'(MAX_TERMS)) && (r_tc != '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_tc   <= '0;
            r_pos  <= '0;
            r_povf <= 1'b0;
            for (int k = 0; k < MAX_TERMS; k++) begin
                r_coef[k] <= '0;
                r_acc[k]  <= '0;
            end
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_res <= w_base;
                        if (i_cmd.opcode != pae_pkg::OP_MUL && i_cmd.opcode <= pae_pkg::OP_EVAL)
                        begin
                            r_pos  <= '0;
                            r_povf <= 1'b0;
                            for (int k = 0; k < MAX_TERMS; k++) r_acc[k] <= '0;
                        end
                        priority if (i_cmd.opcode == pae_pkg::OP_SET ||
                                     i_cmd.opcode == pae_pkg::OP_ADD) begin
                            r_i  <= '0;
                            r_st <= S_OUT;
                            if (32'(i_cmd.coef_index) < 32'(MAX_TERMS)) begin
                                r_coef[IW'(i_cmd.coef_index)] <=
                                    (i_cmd.opcode == pae_pkg::OP_SET) ? i_cmd.coef_value :
                                    r_coef[IW'(i_cmd.coef_index)] + i_cmd.coef_value;
                                if (r_tc <= TW'(i_cmd.coef_index)) begin
                                    r_tc <= TW'(i_cmd.coef_index) + 1'b1;
                                end
                            end
                        end else if (i_cmd.opcode == pae_pkg::OP_MUL) begin
                            r_i    <= '0;
                            r_st   <= S_MUL;
                            r_last <= i_cmd.stream_last;
                        end else if (i_cmd.opcode == pae_pkg::OP_DERIV) begin
                            if (r_tc > TW'(1)) begin
                                r_i  <= TW'(1);
                                r_st <= S_DER;
                            end else begin
                                r_i  <= '0;
                                r_st <= S_OUT;
                            end
                        end else if (i_cmd.opcode == pae_pkg::OP_EVAL) begin
                            r_eovf <= 1'b0;
                            if (r_tc > TW'(1)) begin
                                r_h  <= 64'(signed'(r_coef[IW'(r_tc - 1'b1)])) <<< FRAC_BITS;
                                r_i  <= r_tc - 1'b1;
                                r_st <= S_EMUL;
                            end else begin
                                r_i  <= '0;
                                r_st <= S_OUT;
                            end
                        end else begin
                            r_i  <= '0;
                            r_st <= S_OUT;
                        end
                    end
                end
                S_MUL: begin
                    if ((r_pos < TW'(MAX_TERMS)) && (r_i < r_tc)) begin
                        if ((r_i + r_pos) < TW'(MAX_TERMS)) begin
                            r_acc[IW'(r_i + r_pos)] <= r_acc[IW'(r_i + r_pos)] +
                                r_coef[IW'(r_i)] * r_cmd.coef_value;
                        end else begin
                            r_povf <= 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_st <= S_OUT;
                        r_res.overflow <= w_povf;
                        if (r_last) begin
                            r_tc <= (r_tc == '0) ? '0 :
                                    ((w_n > (TW+1)'(MAX_TERMS - 1)) ? TW'(MAX_TERMS) :
                                     TW'(w_n + 1'b1));
                            for (int k = 0; k < MAX_TERMS; k++) begin
                                r_coef[k] <= r_acc[k];
                                r_acc[k]  <= '0;
                            end
                            r_pos  <= '0;
                            r_povf <= 1'b0;
                        end else begin
                            if (r_pos < TW'(MAX_TERMS)) begin
                                r_pos <= r_pos + 1'b1;
                            end
                            r_povf <= w_povf;
                        end
                    end
                end
                S_DER: begin
                    if (!i_res_full) begin
                        r_i <= r_i + 1'b1;
                        if ((r_i + 1'b1) == r_tc) r_st <= S_IDLE;
                    end
                end
                S_EMUL: begin
                    r_prod <= 96'(w_mp);
                    r_st   <= S_EMH;
                end
                S_EMH: begin
                    r_prod <= r_prod + (96'(w_mp) <<< 32);
                    r_st   <= S_EADD;
                end
                S_EADD: begin
                    r_i <= r_i - 1'b1;
                    if (w_sat) begin
                        r_h    <= w_sum[95] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                        r_eovf <= 1'b1;
                    end else begin
                        r_h <= w_sum[63:0];
                    end
                    if (r_i == TW'(1)) begin
                        r_res.out_value <= w_sat ?
                            (w_sum[95] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : w_sum[63:0];
                        r_res.overflow  <= r_eovf | w_sat;
                        r_st <= S_OUT;
                    end else begin
                        r_st <= S_EMUL;
                    end
                end
                S_OUT: begin
                    if (!i_res_full) r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// File: sv/polynomial_arithmetic_engine_unit.sv
// top level of the polynomial arithmetic engine
//  channel  | handshake    | beat
//  input    | push / full  | t_in_beat
//  result   | pop / empty  | t_out_beat
// a beat is registered in the input queue, then the sequencer decodes it when idle;
// set, add and unused opcodes then go to the result state; multiply accumulates each
// term into the result position (none when the position is saturated); derivative
// emits a beat per non-constant coefficient; evaluate runs a low-half, high-half and add
// state per horner step on a 33x32 multiplier, then the result state. reset clears
// polynomial and queues; input queue takes beats while the sequencer is busy; a full result queue stalls the sequencer.
module polynomial_arithmetic_engine_unit #(
    parameter int MAX_TERMS = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  pae_pkg::t_in_beat  i_in,
    output logic               empty,
    input  logic               pop,
    output pae_pkg::t_out_beat o_out
);
    localparam int IW_B = $bits(pae_pkg::t_in_beat);
    localparam int OW_B = $bits(pae_pkg::t_out_beat);

    logic               w_cmd_empty, w_take, w_res_valid, w_res_full;
    logic [IW_B-1:0]    w_cmd_bits;
    pae_pkg::t_out_beat w_res;
    logic [OW_B-1:0]    w_out_bits;

    pae_fifo #(.WIDTH(IW_B), .DEPTH(2)) u_in_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(i_in), .o_full(full),
        .i_pop(w_take), .o_empty(w_cmd_empty), .o_data(w_cmd_bits)
    );

    pae_back #(.MAX_TERMS(MAX_TERMS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(!w_cmd_empty), .i_cmd(pae_pkg::t_in_beat'(w_cmd_bits)),
        .o_cmd_take(w_take),
        .o_res_valid(w_res_valid), .o_res(w_res), .i_res_full(w_res_full)
    );

    pae_fifo #(.WIDTH(OW_B), .DEPTH(2)) u_out_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_res_valid), .i_data(w_res), .o_full(w_res_full),
        .i_pop(pop), .o_empty(empty), .o_data(w_out_bits)
    );

    assign o_out = pae_pkg::t_out_beat'(w_out_bits);
endmodule
